[design/ordered_key_table_core_macros.svh]
// Assertion macros used by the checker file of the ordered key table.
`ifndef ORDERED_KEY_TABLE_CORE_MACROS_SVH
`define ORDERED_KEY_TABLE_CORE_MACROS_SVH

// Checked only while the block is out of reset.
`define OKT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define OKT_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/okt_pkg.sv]
// Types, widths and command codes of the ordered key table.
`default_nettype none

package okt_pkg;

    localparam int OKT_DEPTH   = 16;
    localparam int KEY_W       = 16;
    localparam int PAYLOAD_W   = 32;
    localparam int COUNT_W     = 5;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_REMOVE = 2'd2
    } okt_cmd_t;

    // Broadcast from the control logic to every cell.
    typedef struct packed {
        logic                 do_append;
        logic                 do_remove;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } okt_ctrl_t;

    // Passed from cell to cell: whether an earlier cell matched, and its entry.
    typedef struct packed {
        logic                 hit;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } okt_chain_t;

endpackage

`default_nettype wire

[design/okt_if.sv]
// Command and result channel interfaces of the ordered key table.
`default_nettype none

interface okt_req_if
    import okt_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [1:0]           cmd;
    logic [KEY_W-1:0]     entry_key;
    logic [PAYLOAD_W-1:0] entry_payload;

    modport source (output valid, cmd, entry_key, entry_payload, input ready);
    modport sink (input valid, cmd, entry_key, entry_payload, output ready);
endinterface

interface okt_rsp_if
    import okt_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [KEY_W-1:0]     found_key;
    logic [PAYLOAD_W-1:0] found_payload;
    logic [COUNT_W-1:0]   entry_count;

    modport source (output valid, ok, found_key, found_payload, entry_count, input ready);
    modport sink (input valid, ok, found_key, found_payload, entry_count, output ready);
endinterface

`default_nettype wire

[design/okt_cell.sv]
// One table slot: holds an entry, compares it, and shifts or loads it.
`default_nettype none

module okt_cell
    import okt_pkg::*;
(
    input  wire logic                 clk,
    input  wire okt_ctrl_t            ctrl,
    input  wire logic                 occupied,
    input  wire logic                 at_tail,
    input  wire okt_chain_t           chain_in,
    output okt_chain_t                chain_out,
    input  wire logic [KEY_W-1:0]     next_key,
    input  wire logic [PAYLOAD_W-1:0] next_payload,
    output logic [KEY_W-1:0]          key,
    output logic [PAYLOAD_W-1:0]      payload
);

    logic [KEY_W-1:0]     key_reg;
    logic [KEY_W-1:0]     key_next;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic [PAYLOAD_W-1:0] payload_next;
    logic                 match;
    logic                 hit_here;

    assign match    = occupied && (key_reg == ctrl.key);
    assign hit_here = match && !chain_in.hit;

    always_comb
    begin
        chain_out.hit     = chain_in.hit || match;
        chain_out.key     = hit_here ? key_reg : chain_in.key;
        chain_out.payload = hit_here ? payload_reg : chain_in.payload;
    end

    // An append loads the tail slot; a removal pulls every slot at or after the first match from its neighbour.
    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (ctrl.do_append && at_tail)
        begin
            key_next     = ctrl.key;
            payload_next = ctrl.payload;
        end
        else if (ctrl.do_remove && chain_out.hit)
        begin
            key_next     = next_key;
            payload_next = next_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign key     = key_reg;
    assign payload = payload_reg;

endmodule

`default_nettype wire

[design/ordered_key_table_core.sv]
// Top level of the ordered key table: cell chain, entry count and result register.
//
// The table holds up to DEPTH key/payload entries in insertion order in a row of
// cells. One command word (append, find, remove) is accepted per clock while the
// output register is empty or being read; its result appears there in the following
// cycle, so a new command is taken in the same cycle the previous result is taken.
// In one pass along the cell chain each cell compares its key, the first match is
// selected and, on removal, the matching cell and every later cell shift down by
// one. Find and remove act on the oldest matching entry. An append to a full
// table, a miss, or the unused command code gives ok low with zero key and payload.
`default_nettype none

module ordered_key_table_core
    import okt_pkg::*;
#(
    parameter int DEPTH = OKT_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    okt_req_if.sink   req,
    okt_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 ok_reg;
    logic                 ok_next;
    logic [KEY_W-1:0]     found_key_reg;
    logic [KEY_W-1:0]     found_key_next;
    logic [PAYLOAD_W-1:0] found_payload_reg;
    logic [PAYLOAD_W-1:0] found_payload_next;

    logic                 accept;
    logic                 full;
    okt_ctrl_t            ctrl;
    okt_chain_t           chain [DEPTH+1];
    logic [KEY_W-1:0]     cell_key [DEPTH];
    logic [PAYLOAD_W-1:0] cell_payload [DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        ctrl.do_append = accept && (req.cmd == CMD_APPEND) && !full;
        ctrl.do_remove = accept && (req.cmd == CMD_REMOVE);
        ctrl.key       = req.entry_key;
        ctrl.payload   = req.entry_payload;
    end

    assign chain[0] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
        localparam int NEXT = (i == DEPTH - 1) ? i : i + 1;

        okt_cell u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .occupied     (IDX < count_reg),
            .at_tail      (IDX == count_reg),
            .chain_in     (chain[i]),
            .chain_out    (chain[i+1]),
            .next_key     (cell_key[NEXT]),
            .next_payload (cell_payload[NEXT]),
            .key          (cell_key[i]),
            .payload      (cell_payload[i])
        );
    end

    always_comb
    begin
        ok_next            = 1'b0;
        found_key_next     = '0;
        found_payload_next = '0;
        count_next         = count_reg;
        case (req.cmd)
            CMD_APPEND:
            begin
                ok_next = !full;
                if (!full)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_FIND:
            begin
                ok_next            = chain[DEPTH].hit;
                found_key_next     = chain[DEPTH].key;
                found_payload_next = chain[DEPTH].payload;
            end
            CMD_REMOVE:
            begin
                ok_next            = chain[DEPTH].hit;
                found_key_next     = chain[DEPTH].key;
                found_payload_next = chain[DEPTH].payload;
                if (chain[DEPTH].hit)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg            <= ok_next;
            found_key_reg     <= found_key_next;
            found_payload_reg <= found_payload_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.ok            = ok_reg;
    assign rsp.found_key     = found_key_reg;
    assign rsp.found_payload = found_payload_reg;
    assign rsp.entry_count   = COUNT_W'(count_reg);

endmodule

`default_nettype wire

[design/okt_checker.sv]
// Port-level assertions for the ordered key table, bound to its top level.
`default_nettype none

`include "ordered_key_table_core_macros.svh"

module okt_checker
    import okt_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 req_valid,
    input wire logic                 req_ready,
    input wire logic                 rsp_valid,
    input wire logic                 rsp_ready,
    input wire logic                 ok,
    input wire logic [KEY_W-1:0]     found_key,
    input wire logic [PAYLOAD_W-1:0] found_payload,
    input wire logic [COUNT_W-1:0]   entry_count
);

    `OKT_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !rsp_valid, "result word valid in reset")

    `OKT_ASSERT(a_accept_gives_result, (req_valid && req_ready) |=> rsp_valid, "accepted word gave no result")

    `OKT_ASSERT(a_miss_is_zero, (rsp_valid && !ok) |-> (found_key == '0 && found_payload == '0), "failed command returned an entry")

    `OKT_ASSERT(a_stall_holds, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(ok) && $stable(entry_count)), "stalled result word changed")

endmodule

bind ordered_key_table_core okt_checker u_okt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .ok            (rsp.ok),
    .found_key     (rsp.found_key),
    .found_payload (rsp.found_payload),
    .entry_count   (rsp.entry_count)
);

`default_nettype wire
